/* design/byte_ring_buffer_with_peek_macros.svh */
`ifndef BYTE_RING_BUFFER_WITH_PEEK_MACROS_SVH
`define BYTE_RING_BUFFER_WITH_PEEK_MACROS_SVH

// same-cycle implication, off while reset is asserted
`define BRB_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// implication checked in the next cycle
`define BRB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/brb_pkg.sv */
`timescale 1ns / 1ps
package brb_pkg;

	localparam int CW = 10;
	localparam int LW = 7;
	localparam int APB_AW = 3;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_READ = 2'd1;
	localparam logic [1:0] OP_PEEK = 2'd2;
	localparam logic [1:0] OP_CLEAR = 2'd3;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_OVERFLOW = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	localparam logic [CW-1:0] CAP_RESET = 10'd1023;

	typedef enum logic [1:0] {
		K_WRITE = 2'd0,
		K_READ = 2'd1,
		K_NOTE = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		FR_IDLE = 2'b01,
		FR_RUN = 2'b10
	} front_state_t;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] data_byte;
		logic burst_start;
		logic [9:0] burst_length;
		logic [6:0] read_length;
		logic [9:0] peek_offset;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] out_byte;
		logic byte_valid;
		logic last;
		logic [9:0] bytes_used;
		logic [9:0] bytes_free;
	} rsp_t;

	// one queued operation for the back end
	typedef struct packed {
		kind_t kind;
		logic [7:0] data;
		logic [1:0] status;
		logic last;
		logic [CW-1:0] bytes_used;
		logic [CW-1:0] bytes_free;
	} cmd_t;

endpackage

/* design/brb_ram.sv */
`timescale 1ns / 1ps
module brb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input logic clk,
	input logic we,
	input logic [AW-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [AW-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* design/brb_queue.sv */
`timescale 1ns / 1ps
module brb_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4,
	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int NW = $clog2(DEPTH + 1)
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input logic [WIDTH-1:0] push_data,
	output logic full,
	input logic pop,
	output logic [WIDTH-1:0] pop_data,
	output logic empty
);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [IW-1:0] wr_ptr_q;
	logic [IW-1:0] rd_ptr_q;
	logic [NW-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign full = (count_q == NW'(DEPTH));
	assign empty = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign pop_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == IW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == IW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* design/brb_front.sv */
`timescale 1ns / 1ps
`include "byte_ring_buffer_with_peek_macros.svh"
module brb_front import brb_pkg::*; #(
	parameter int SLOTS = 1024,
	parameter int MAX_READ_RUN = 64,
	localparam int PW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_wr,
	input logic [CW-1:0] cap,
	input logic req_valid,
	output logic req_stall,
	input req_t req_data,
	output logic push,
	output logic [PW-1:0] push_addr,
	output cmd_t push_cmd,
	input logic q_full
);

	localparam int SW = ((PW > CW) ? PW : CW) + 1;
	localparam logic [LW-1:0] RUN_MAX = LW'(MAX_READ_RUN);

	front_state_t state_q, state_d;
	logic [PW-1:0] wp_q, wp_d;
	logic [PW-1:0] rp_q, rp_d;
	logic [CW-1:0] used_q, used_d;
	logic rej_q, rej_d;
	logic [LW-1:0] left_q, left_d;

	logic acc;
	logic rej_w;
	logic [CW-1:0] free;
	logic [PW-1:0] wp_adv;
	logic [PW-1:0] rp_adv;
	logic [LW-1:0] rsat;
	logic [CW-1:0] rcount;
	logic [SW-1:0] peek_sum;
	logic [SW-1:0] peek_idx;

	assign req_stall = (state_q == FR_RUN) || q_full;
	assign acc = req_valid && !req_stall;
	assign free = cap - used_q;

	// pointers wrap when they pass the last slot of the ring
	assign wp_adv = (SW'(wp_q) >= SW'(cap)) ? '0 : wp_q + 1'b1;
	assign rp_adv = (SW'(rp_q) >= SW'(cap)) ? '0 : rp_q + 1'b1;

	assign rsat = (req_data.read_length > RUN_MAX) ? RUN_MAX : req_data.read_length;
	assign rcount = (used_q < CW'(rsat)) ? used_q : CW'(rsat);

	assign peek_sum = SW'(rp_q) + SW'(req_data.peek_offset);
	assign peek_idx = (peek_sum > SW'(cap)) ? peek_sum - SW'(cap) - SW'(1) : peek_sum;

	always_comb begin
		state_d = state_q;
		wp_d = wp_q;
		rp_d = rp_q;
		used_d = used_q;
		rej_d = rej_q;
		left_d = left_q;
		rej_w = rej_q;
		push = 1'b0;
		push_addr = rp_q;
		push_cmd.kind = K_NOTE;
		push_cmd.data = req_data.data_byte;
		push_cmd.status = ST_OK;
		push_cmd.last = 1'b1;
		case (state_q)
			FR_IDLE: begin
				if (acc) begin
					push = 1'b1;
					case (req_data.opcode)
						OP_WRITE: begin
							if (req_data.burst_start) begin
								rej_w = (free < req_data.burst_length);
							end
							rej_d = rej_w;
							if (rej_w || free == '0) begin
								push_cmd.status = ST_OVERFLOW;
							end else begin
								push_cmd.kind = K_WRITE;
								push_addr = wp_q;
								wp_d = wp_adv;
								used_d = used_q + 1'b1;
							end
						end
						OP_READ: begin
							if (rcount != '0) begin
								push_cmd.kind = K_READ;
								push_cmd.last = (rcount == CW'(1));
								rp_d = rp_adv;
								used_d = used_q - rcount;
								if (rcount != CW'(1)) begin
									state_d = FR_RUN;
									left_d = LW'(rcount - CW'(1));
								end
							end
						end
						OP_PEEK: begin
							if (req_data.peek_offset >= used_q) begin
								push_cmd.status = ST_RANGE;
							end else begin
								push_cmd.kind = K_READ;
								push_addr = PW'(peek_idx);
							end
						end
						OP_CLEAR: begin
							wp_d = '0;
							rp_d = '0;
							used_d = '0;
							rej_d = 1'b0;
						end
						default: begin
							push_cmd.status = ST_OK;
						end
					endcase
				end
			end
			FR_RUN: begin
				// rest of a read run, one byte a cycle unless q_full; counts were settled at accept
				if (!q_full) begin
					push = 1'b1;
					push_cmd.kind = K_READ;
					push_cmd.last = (left_q == LW'(1));
					rp_d = rp_adv;
					left_d = left_q - 1'b1;
					if (left_q == LW'(1)) begin
						state_d = FR_IDLE;
					end
				end
			end
			default: begin
				state_d = FR_IDLE;
			end
		endcase
		push_cmd.bytes_used = used_d;
		push_cmd.bytes_free = cap - used_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FR_IDLE;
			wp_q <= '0;
			rp_q <= '0;
			used_q <= '0;
			rej_q <= 1'b0;
			left_q <= '0;
		end else if (cfg_wr) begin
			state_q <= FR_IDLE;
			wp_q <= '0;
			rp_q <= '0;
			used_q <= '0;
			rej_q <= 1'b0;
			left_q <= '0;
		end else begin
			state_q <= state_d;
			wp_q <= wp_d;
			rp_q <= rp_d;
			used_q <= used_d;
			rej_q <= rej_d;
			left_q <= left_d;
		end
	end

	`BRB_ASSERT_NOW(a_used_within_cap, 1'b1, used_q <= cap, "fill count above capacity")
	`BRB_ASSERT_NOW(a_empty_pointers, used_q == '0 && state_q == FR_IDLE, wp_q == rp_q, "empty ring with split pointers")
	`BRB_ASSERT_NEXT(a_clear_empties, acc && req_data.opcode == OP_CLEAR, used_q == '0 && rp_q == '0 && !rej_q, "clear left data behind")

endmodule

/* design/brb_back.sv */
`timescale 1ns / 1ps
`include "byte_ring_buffer_with_peek_macros.svh"
module brb_back import brb_pkg::*; #(
	parameter int SLOTS = 1024,
	localparam int PW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
	input logic clk,
	input logic arst_n,
	input logic q_empty,
	input logic [PW+$bits(cmd_t)-1:0] q_data,
	output logic q_pop,
	output logic rsp_valid,
	input logic rsp_stall,
	output rsp_t rsp_data
);

	logic [PW-1:0] head_addr;
	cmd_t head_cmd;
	logic valid_s1;
	cmd_t cmd_s1;
	logic out_valid_q;
	rsp_t out_q;
	logic s1_move;
	logic ram_we;
	logic ram_re;
	logic [7:0] ram_rdata;
	rsp_t res;

	assign {head_addr, head_cmd} = q_data;

	assign s1_move = valid_s1 && (!out_valid_q || !rsp_stall);
	assign q_pop = !q_empty && (!valid_s1 || s1_move);

	// writes and reads leave the queue in order, so a read sees every earlier write
	assign ram_we = q_pop && (head_cmd.kind == K_WRITE);
	assign ram_re = q_pop && (head_cmd.kind == K_READ);

	brb_ram #(
		.WIDTH(8),
		.DEPTH(SLOTS)
	) u_store (
		.clk(clk),
		.we(ram_we),
		.waddr(head_addr),
		.wdata(head_cmd.data),
		.re(ram_re),
		.raddr(head_addr),
		.rdata(ram_rdata)
	);

	always_comb begin
		res.status = cmd_s1.status;
		res.out_byte = (cmd_s1.kind == K_READ) ? ram_rdata : 8'd0;
		res.byte_valid = (cmd_s1.kind == K_READ);
		res.last = cmd_s1.last;
		res.bytes_used = cmd_s1.bytes_used;
		res.bytes_free = cmd_s1.bytes_free;
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_s1 <= head_cmd;
		end
		if (s1_move) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				valid_s1 <= 1'b1;
			end else if (s1_move) begin
				valid_s1 <= 1'b0;
			end
			if (s1_move) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp_data = out_q;

	`BRB_ASSERT_NOW(a_byte_is_ok, out_valid_q && out_q.byte_valid, out_q.status == ST_OK, "byte delivered with error status")

endmodule

/* design/byte_ring_buffer_with_peek.sv */
`timescale 1ns / 1ps
// Byte ring buffer with peek.
// Requests arrive on req_valid/req_stall/req_data: write a byte, read a run of
// bytes, peek at an offset from the read position, or clear. Results leave on
// rsp_valid/rsp_stall/rsp_data, each with the used and free counts after its request.
// The front end takes a request per cycle while req_stall is low, checks space and
// moves the pointers, and hands each operation to a 4-entry queue; the back end runs
// them against the byte store (one write or one registered read per cycle unless
// rsp_stall holds the output) into an output register. Write, peek and clear give one
// result each; a read run of more than one byte holds req_stall until its last byte
// is queued and delivers one byte per cycle while rsp_stall is low.
// usable_capacity sits at APB address 0; writing it empties the ring.
// Reset empties the ring and sets the capacity to 1023; the byte store itself is
// not cleared, so there is no start-up sweep.
// When rsp_stall is held, the output register, one staged operation and the queue
// fill up, then req_stall rises until results drain.
module byte_ring_buffer_with_peek import brb_pkg::*; #(
	parameter int SLOTS = 1024,
	parameter int MAX_READ_RUN = 64
) (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [APB_AW-1:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input logic req_valid,
	output logic req_stall,
	input req_t req_data,
	output logic rsp_valid,
	input logic rsp_stall,
	output rsp_t rsp_data
);

	localparam int PW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int QW = PW + $bits(cmd_t);
	localparam logic [31:0] CAP_MAX = 32'(SLOTS - 1);

	logic [CW-1:0] cap_raw_q;
	logic [CW-1:0] cap;
	logic cap_sel;
	logic cfg_wr;
	logic push;
	logic [PW-1:0] push_addr;
	cmd_t push_cmd;
	logic q_full;
	logic q_empty;
	logic q_pop;
	logic [QW-1:0] q_data;

	assign pready = 1'b1;
	assign cap_sel = (paddr[APB_AW-1] == 1'b0);
	assign cfg_wr = psel && penable && pwrite && pready && cap_sel;
	assign prdata = cap_sel ? 32'(cap_raw_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_raw_q <= CAP_RESET;
		end else if (cfg_wr) begin
			cap_raw_q <= pwdata[CW-1:0];
		end
	end

	// zero acts as one, anything past the store acts as its last slot
	always_comb begin
		if (cap_raw_q == '0) begin
			cap = CW'(1);
		end else if (32'(cap_raw_q) > CAP_MAX) begin
			cap = CAP_MAX[CW-1:0];
		end else begin
			cap = cap_raw_q;
		end
	end

	brb_front #(
		.SLOTS(SLOTS),
		.MAX_READ_RUN(MAX_READ_RUN)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr(cfg_wr),
		.cap(cap),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_data(req_data),
		.push(push),
		.push_addr(push_addr),
		.push_cmd(push_cmd),
		.q_full(q_full)
	);

	brb_queue #(
		.WIDTH(QW),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data({push_addr, push_cmd}),
		.full(q_full),
		.pop(q_pop),
		.pop_data(q_data),
		.empty(q_empty)
	);

	brb_back #(
		.SLOTS(SLOTS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_empty(q_empty),
		.q_data(q_data),
		.q_pop(q_pop),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_data(rsp_data)
	);

endmodule

/* tb/tb_byte_ring_buffer_with_peek.sv */
`timescale 1ns / 1ps
module tb_byte_ring_buffer_with_peek;
	import brb_pkg::*;

	localparam int MAX_RUN = 64;
	localparam int HOLD_CYCLES = 260;
	localparam int STALL_LIMIT = 4000;
	localparam logic [APB_AW-1:0] REG_USABLE_CAPACITY = '0;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [APB_AW-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req_data = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp_data;

	byte_ring_buffer_with_peek i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_data(req_data),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_data(rsp_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// shadow copy of the ring
	logic [7:0] shadow_bytes [0:1023];
	int unsigned shadow_wr = 0;
	int unsigned shadow_rd = 0;
	bit shadow_rejected = 1'b0;
	logic [9:0] shadow_cap = CAP_RESET;

	req_t request_backlog[$];
	rsp_t ring_results[$];

	int mismatches = 0;
	int accepted_requests = 0;
	int results_seen = 0;
	int capacity_settings = 0;
	int gap_left = 0;
	int stall_left = 0;
	int hold_left = 0;
	int holds_asked = 0;
	int holds_served = 0;
	int span = 0;
	int idle_cycles = 0;
	bit quiet_phase = 1'b0;

	function automatic int unsigned ring_slot_count();
		return ((shadow_cap == 0) ? 1 : shadow_cap) + 1;
	endfunction

	function automatic int unsigned ring_used();
		if (shadow_wr >= shadow_rd)
			return shadow_wr - shadow_rd;
		return ring_slot_count() + shadow_wr - shadow_rd;
	endfunction

	function automatic int unsigned ring_free();
		return ring_slot_count() - 1 - ring_used();
	endfunction

	// wrap by compare
	function automatic int unsigned ring_next(int unsigned pos);
		return (pos + 1 >= ring_slot_count()) ? 0 : pos + 1;
	endfunction

	function automatic void apply_ring_request(req_t r);
		rsp_t run[$];
		rsp_t one;
		int unsigned take;
		int unsigned idx;
		one = '0;
		one.last = 1'b1;
		case (r.opcode)
			OP_WRITE: begin
				if (r.burst_start)
					shadow_rejected = (ring_free() < r.burst_length);
				if (shadow_rejected || ring_free() == 0) begin
					one.status = ST_OVERFLOW;
				end else begin
					shadow_bytes[shadow_wr] = r.data_byte;
					shadow_wr = ring_next(shadow_wr);
				end
				run.push_back(one);
			end
			OP_READ: begin
				take = (r.read_length > MAX_RUN) ? MAX_RUN : r.read_length;
				if (take > ring_used())
					take = ring_used();
				if (take == 0)
					run.push_back(one);
				for (int i = 0; i < take; i++) begin
					one.out_byte = shadow_bytes[shadow_rd];
					one.byte_valid = 1'b1;
					one.last = (i + 1 == take);
					run.push_back(one);
					shadow_rd = ring_next(shadow_rd);
				end
			end
			OP_PEEK: begin
				if (r.peek_offset >= ring_used()) begin
					one.status = ST_RANGE;
				end else begin
					idx = shadow_rd + r.peek_offset;
					if (idx >= ring_slot_count())
						idx -= ring_slot_count();
					one.out_byte = shadow_bytes[idx];
					one.byte_valid = 1'b1;
				end
				run.push_back(one);
			end
			default: begin
				shadow_wr = 0;
				shadow_rd = 0;
				shadow_rejected = 1'b0;
				run.push_back(one);
			end
		endcase
		// counts are taken after the whole request
		foreach (run[k]) begin
			run[k].bytes_used = 10'(ring_used());
			run[k].bytes_free = 10'(ring_free());
			ring_results.push_back(run[k]);
		end
	endfunction

	task automatic report_mismatch(string msg);
		mismatches++;
		if (mismatches <= 40)
			$display("%0t ns: %s", $time, msg);
	endtask

	task automatic check_field(string name, logic [9:0] got, logic [9:0] want);
		if (got !== want)
			report_mismatch($sformatf("result %0d: %s is %0h, expected %0h",
				results_seen, name, got, want));
	endtask

	task automatic check_result(rsp_t got);
		rsp_t want;
		if (ring_results.size() == 0) begin
			report_mismatch($sformatf("result %0d arrived with none expected", results_seen));
		end else begin
			want = ring_results.pop_front();
			check_field("status", got.status, want.status);
			check_field("out_byte", got.out_byte, want.out_byte);
			check_field("byte_valid", got.byte_valid, want.byte_valid);
			check_field("last", got.last, want.last);
			check_field("bytes_used", got.bytes_used, want.bytes_used);
			check_field("bytes_free", got.bytes_free, want.bytes_free);
		end
		results_seen++;
	endtask

	// mostly no gap, some short ones, a few long ones
	function automatic int idle_span();
		int p;
		p = $urandom_range(0, 99);
		if (p < 65)
			return 0;
		if (p < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic req_t make_req(logic [1:0] op, logic [7:0] d, logic s,
			logic [9:0] bl, logic [6:0] rl, logic [9:0] off);
		req_t r;
		r.opcode = op;
		r.data_byte = d;
		r.burst_start = s;
		r.burst_length = bl;
		r.read_length = rl;
		r.peek_offset = off;
		return r;
	endfunction

	function automatic req_t noisy_req(logic [1:0] op);
		return make_req(op, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
			10'($urandom_range(0, 1023)), 7'($urandom_range(0, 127)),
			10'($urandom_range(0, 1023)));
	endfunction

	// well-formed bursts with random content, plus reads, peeks, clears and some noise
	function automatic void plan_random_traffic(int n_items, int eff_cap);
		int est;
		int pushed;
		int n;
		int blen;
		int p;
		int fits;
		req_t r;
		est = 0;
		pushed = 0;
		while (pushed < n_items) begin
			p = $urandom_range(0, 99);
			if (p < 45) begin
				n = $urandom_range(1, (eff_cap + 1 < 48) ? eff_cap + 1 : 48);
				p = $urandom_range(0, 99);
				if (p < 75)
					blen = n;
				else if (p < 85)
					blen = $urandom_range(0, n - 1);
				else if (p < 90)
					blen = 0;
				else
					blen = $urandom_range(n, 1023);
				for (int i = 0; i < n; i++) begin
					r = noisy_req(OP_WRITE);
					r.burst_start = (i == 0);
					if (i == 0)
						r.burst_length = 10'(blen);
					request_backlog.push_back(r);
				end
				pushed += n;
				if (blen <= eff_cap - est) begin
					fits = eff_cap - est;
					est += (n < fits) ? n : fits;
				end
			end else if (p < 75) begin
				r = noisy_req(OP_READ);
				if ($urandom_range(0, 99) < 70)
					r.read_length = 7'($urandom_range(1, 64));
				request_backlog.push_back(r);
				pushed++;
				n = (r.read_length > MAX_RUN) ? MAX_RUN : r.read_length;
				est -= (n < est) ? n : est;
			end else if (p < 90) begin
				r = noisy_req(OP_PEEK);
				if (est > 0 && $urandom_range(0, 99) < 70)
					r.peek_offset = 10'($urandom_range(0, est - 1));
				request_backlog.push_back(r);
				pushed++;
			end else if (p < 95) begin
				request_backlog.push_back(noisy_req(OP_CLEAR));
				pushed++;
				est = 0;
			end else begin
				// stray byte outside any burst
				r = noisy_req(OP_WRITE);
				r.burst_start = 1'b0;
				request_backlog.push_back(r);
				pushed++;
				if (est < eff_cap)
					est++;
			end
		end
	endfunction

	task automatic apb_access(input logic wr, input logic [31:0] wdata,
			output logic [31:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= REG_USABLE_CAPACITY;
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic program_capacity(logic [31:0] value);
		logic [31:0] readback;
		apb_access(1'b1, value, readback);
		shadow_cap = value[9:0];
		shadow_wr = 0;
		shadow_rd = 0;
		shadow_rejected = 1'b0;
		capacity_settings++;
		@(posedge clk);
		apb_access(1'b0, '0, readback);
		if (readback !== {22'd0, value[9:0]})
			report_mismatch($sformatf("usable_capacity reads %0h, expected %0h",
				readback, value[9:0]));
	endtask

	task automatic wait_drained();
		do begin
			while (request_backlog.size() != 0 || req_valid || ring_results.size() != 0)
				@(posedge clk);
			repeat (3) @(posedge clk);
		end while (request_backlog.size() != 0 || req_valid || ring_results.size() != 0);
	endtask

	// request driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall) begin
				apply_ring_request(req_data);
				accepted_requests++;
			end
			if (!req_valid || !req_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					req_valid <= 1'b0;
				end else if (request_backlog.size() > 0) begin
					req_data <= request_backlog.pop_front();
					req_valid <= 1'b1;
					gap_left = quiet_phase ? 0 : idle_span();
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and receiver stalls
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && !rsp_stall)
				check_result(rsp_data);
			if (holds_served < holds_asked) begin
				holds_served++;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				rsp_stall <= 1'b1;
			end else begin
				span = quiet_phase ? 0 : idle_span();
				if (span > 0) begin
					stall_left = span - 1;
					rsp_stall <= 1'b1;
				end else begin
					rsp_stall <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || psel)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("no progress for %0d cycles", STALL_LIMIT);
				$display("byte_ring_buffer_with_peek test failed");
				$finish;
			end
		end
	end

	initial begin
		logic [31:0] cap_plan [7];
		int eff;
		req_t r;
		cap_plan = '{32'd1, 32'd0, 32'd5, 32'd1023, 32'hABCD_FC0B, 32'd64, 32'd0};
		cap_plan[6] = $urandom_range(2, 300);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part at the reset capacity
		request_backlog.push_back(make_req(OP_READ, 8'h00, 1'b0, 10'd0, 7'd5, 10'd0));
		request_backlog.push_back(make_req(OP_PEEK, 8'h00, 1'b0, 10'd0, 7'd0, 10'd0));
		request_backlog.push_back(make_req(OP_WRITE, 8'h00, 1'b1, 10'd0, 7'd0, 10'd0));
		request_backlog.push_back(make_req(OP_WRITE, 8'hFF, 1'b1, 10'd3, 7'd0, 10'd0));
		request_backlog.push_back(make_req(OP_WRITE, 8'h5A, 1'b0, 10'd0, 7'd0, 10'd0));
		request_backlog.push_back(make_req(OP_WRITE, 8'hA5, 1'b0, 10'd1023, 7'd127, 10'd1023));
		request_backlog.push_back(make_req(OP_PEEK, 8'h00, 1'b0, 10'd0, 7'd0, 10'd0));
		request_backlog.push_back(make_req(OP_PEEK, 8'hFF, 1'b1, 10'd1023, 7'd127, 10'd3));
		request_backlog.push_back(make_req(OP_PEEK, 8'h00, 1'b0, 10'd0, 7'd0, 10'd4));
		request_backlog.push_back(make_req(OP_PEEK, 8'h00, 1'b0, 10'd0, 7'd0, 10'd1023));
		request_backlog.push_back(make_req(OP_READ, 8'h00, 1'b0, 10'd0, 7'd0, 10'd0));
		request_backlog.push_back(make_req(OP_READ, 8'h00, 1'b0, 10'd0, 7'd2, 10'd0));
		request_backlog.push_back(make_req(OP_READ, 8'hFF, 1'b1, 10'd1023, 7'd127, 10'd1023));
		// a burst of the whole capacity passes the check on an empty ring
		request_backlog.push_back(make_req(OP_WRITE, 8'h11, 1'b1, 10'd1023, 7'd0, 10'd0));
		request_backlog.push_back(make_req(OP_WRITE, 8'h22, 1'b1, 10'd1023, 7'd0, 10'd0));
		request_backlog.push_back(make_req(OP_WRITE, 8'h33, 1'b0, 10'd0, 7'd0, 10'd0));
		request_backlog.push_back(make_req(OP_CLEAR, 8'hFF, 1'b1, 10'd1023, 7'd127, 10'd1023));
		request_backlog.push_back(make_req(OP_WRITE, 8'h77, 1'b0, 10'd0, 7'd0, 10'd0));
		request_backlog.push_back(make_req(OP_WRITE, 8'h44, 1'b1, 10'd1023, 7'd0, 10'd0));
		request_backlog.push_back(make_req(OP_CLEAR, 8'h00, 1'b0, 10'd0, 7'd0, 10'd0));
		request_backlog.push_back(make_req(OP_READ, 8'h00, 1'b0, 10'd0, 7'd1, 10'd0));
		request_backlog.push_back(make_req(OP_WRITE, 8'h80, 1'b1, 10'd2, 7'd0, 10'd0));
		request_backlog.push_back(make_req(OP_WRITE, 8'h01, 1'b0, 10'd0, 7'd0, 10'd0));
		request_backlog.push_back(make_req(OP_READ, 8'h00, 1'b0, 10'd0, 7'd64, 10'd0));
		wait_drained();

		foreach (cap_plan[p]) begin
			program_capacity(cap_plan[p]);
			quiet_phase = (p == 5);
			eff = (cap_plan[p][9:0] == 0) ? 1 : cap_plan[p][9:0];
			plan_random_traffic(45, eff);
			wait_drained();
		end
		quiet_phase = 1'b0;

		// receiver holds off while a long burst and two long reads queue up
		program_capacity(32'd1023);
		holds_asked++;
		for (int i = 0; i < 90; i++) begin
			r = noisy_req(OP_WRITE);
			r.burst_start = (i == 0);
			if (i == 0)
				r.burst_length = 10'd90;
			request_backlog.push_back(r);
		end
		request_backlog.push_back(make_req(OP_READ, 8'h00, 1'b0, 10'd0, 7'd127, 10'd0));
		request_backlog.push_back(make_req(OP_READ, 8'h00, 1'b0, 10'd0, 7'd100, 10'd0));
		wait_drained();

		repeat (8) @(posedge clk);
		if (ring_results.size() != 0)
			report_mismatch($sformatf("%0d expected results never arrived",
				ring_results.size()));
		$display("%0d requests in, %0d results checked over %0d capacity settings",
			accepted_requests, results_seen, capacity_settings);
		$display("directed cases, random bursts, reads, peeks, clears, long receiver hold");
		if (mismatches == 0)
			$display("byte_ring_buffer_with_peek test passed");
		else
			$display("byte_ring_buffer_with_peek test failed");
		$finish;
	end

endmodule

/* sim.f */
+incdir+design
design/brb_pkg.sv
design/brb_ram.sv
design/brb_queue.sv
design/brb_front.sv
design/brb_back.sv
design/byte_ring_buffer_with_peek.sv
tb/tb_byte_ring_buffer_with_peek.sv
